### sv/iirtf_pkg.sv
`default_nettype none

package iirtf_pkg;

	// Field and arithmetic widths
	localparam int SampleW = 16;
	localparam int CoefW   = 24;
	localparam int DelayW  = 44;
	localparam int FracW   = 20;
	localparam int ProdW   = CoefW + SampleW;   // coefficient times sample
	localparam int AccW    = DelayW + 1;        // product plus delay element
	localparam int UpdW    = DelayW + 2;        // two products plus delay element
	localparam int CfgIdxW = 3;

	// Register indexes on the configuration port
	localparam logic [CfgIdxW-1:0] REG_FF_COEF_0 = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_FF_COEF_1 = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_FF_COEF_2 = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_FB_COEF_1 = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_FB_COEF_2 = 3'd4;

	// Item opcodes
	localparam logic OP_FILTER  = 1'b0;
	localparam logic OP_PRELOAD = 1'b1;

	// 1.0 in Q4.20
	localparam logic signed [CoefW-1:0] CoefOne = 24'sh100000;

	typedef struct packed {
		logic                      opcode;
		logic signed [SampleW-1:0] sample_in;
		logic                      delay_index;
		logic signed [DelayW-1:0]  delay_value;
	} in_item_t;

	typedef struct packed {
		logic signed [SampleW-1:0] sample_out;
		logic                      saturated;
	} out_item_t;

	typedef struct packed {
		logic signed [CoefW-1:0] b0;
		logic signed [CoefW-1:0] b1;
		logic signed [CoefW-1:0] b2;
		logic signed [CoefW-1:0] a1;
		logic signed [CoefW-1:0] a2;
	} coef_set_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_item;   // capture the accepted transaction
		logic mac1;        // output sample and feed-forward products
		logic mac2;        // feedback products and delay update
		logic preload;     // write one delay element
		logic push;        // move the result into the output register
	} dp_cmd_t;

endpackage

`default_nettype wire

### sv/iir_transposed_direct_form_filter_core.sv
// Filter transaction: two multiply-add steps in sequence, then the result is
// registered; the next one is taken only as the result is pushed out.
// Preload transaction: writes one delay element, no result.
// A result waiting in the output register blocks only the next result.
// Asynchronous active-low reset: b0 = 1.0, other coefficients and delays zero.
`default_nettype none

module iir_transposed_direct_form_filter_core
	import iirtf_pkg::*;
#(
	parameter int ORDER = 2
)
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  wire               out_stall,
	output out_item_t         out_data,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire [CfgIdxW-1:0] cfg_index,
	input  wire [CoefW-1:0]   cfg_data
);

	coef_set_t coef;
	dp_cmd_t   cmd;

	// Coefficients may be written at any cycle
	assign cfg_ready = 1'b1;

	iirtf_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.coef     (coef)
	);

	iirtf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_opcode (in_data.opcode),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	iirtf_datapath #(
		.ORDER (ORDER)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.coef     (coef),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

### sv/iirtf_cfg_regs.sv
`default_nettype none

module iirtf_cfg_regs
	import iirtf_pkg::*;
(
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       wr_en,
	input  wire [CfgIdxW-1:0]         wr_index,
	input  wire [CoefW-1:0]           wr_data,
	output coef_set_t                 coef
);

	coef_set_t coef_q;

	// Coefficient register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= CoefOne;
			coef_q.b1 <= '0;
			coef_q.b2 <= '0;
			coef_q.a1 <= '0;
			coef_q.a2 <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FF_COEF_0: coef_q.b0 <= wr_data;
				REG_FF_COEF_1: coef_q.b1 <= wr_data;
				REG_FF_COEF_2: coef_q.b2 <= wr_data;
				REG_FB_COEF_1: coef_q.a1 <= wr_data;
				REG_FB_COEF_2: coef_q.a2 <= wr_data;
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

`default_nettype wire

### sv/iirtf_ctrl.sv
`default_nettype none

module iirtf_ctrl
	import iirtf_pkg::*;
(
	input  wire     clk,
	input  wire     arst_n,
	input  wire     in_valid,
	input  wire     in_opcode,
	input  wire     out_stall,
	output logic    in_stall,
	output logic    out_valid,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC1,
		ST_MAC2,
		ST_HOLD,
		ST_LOAD
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;
	logic   out_free, has_result, push, take, accept;
	state_t after_take;

	// Handshake decode
	always_comb begin
		out_free   = !out_valid_q || !out_stall;
		has_result = (state_q == ST_MAC2) || (state_q == ST_HOLD);
		push       = has_result && out_free;
		take       = (state_q == ST_IDLE) || (state_q == ST_LOAD) || push;
		accept     = in_valid && take;
		after_take = !accept ? ST_IDLE :
		             (in_opcode == OP_PRELOAD) ? ST_LOAD : ST_MAC1;
	end

	// Next state
	always_comb begin
		unique case (state_q)
			ST_IDLE, ST_LOAD: state_d = after_take;
			ST_MAC1:          state_d = ST_MAC2;
			ST_MAC2, ST_HOLD: state_d = push ? after_take : ST_HOLD;
			default:          state_d = ST_IDLE;
		endcase
		out_valid_d = push ? 1'b1 : (out_valid_q && out_stall);
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Datapath commands
	always_comb begin
		cmd.load_item = accept;
		cmd.mac1      = (state_q == ST_MAC1);
		cmd.mac2      = (state_q == ST_MAC2);
		cmd.preload   = (state_q == ST_LOAD);
		cmd.push      = push;
	end

	assign in_stall  = !take;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### sv/iirtf_datapath.sv
`default_nettype none

module iirtf_datapath
	import iirtf_pkg::*;
#(
	parameter int ORDER = 2
)
(
	input  wire       clk,
	input  wire       arst_n,
	input  dp_cmd_t   cmd,
	input  in_item_t  in_data,
	input  coef_set_t coef,
	output out_item_t out_data
);

	localparam logic signed [AccW-1:0] RoundHalf = AccW'(1) <<< (FracW - 1);
	localparam int SatTop = FracW + SampleW - 1;

	in_item_t                  item_q;
	logic signed [DelayW-1:0]  delay_q [ORDER];
	logic signed [SampleW-1:0] y_q;
	logic                      sat_q;
	out_item_t                 out_q;

	logic signed [ProdW-1:0]   prod0;
	logic signed [AccW-1:0]    acc;
	logic                      y_clip;
	logic signed [SampleW-1:0] y_d;

	// Transaction capture
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_data;
		end
	end

	// First step: b0*x + d0, round half up, clip to 16 bits
	always_comb begin
		prod0  = coef.b0 * item_q.sample_in;
		acc    = AccW'(prod0) + AccW'(delay_q[0]) + RoundHalf;
		y_clip = !((&acc[AccW-1:SatTop]) || !(|acc[AccW-1:SatTop]));
		if (y_clip) begin
			y_d = acc[AccW-1] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}};
		end else begin
			y_d = acc[SatTop:FracW];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mac1) begin
			y_q   <= y_d;
			sat_q <= y_clip;
		end
	end

	// One lane per delay element
	for (genvar k = 0; k < ORDER; k++) begin : g_tap
		logic signed [CoefW-1:0]  b_k, a_k;
		logic signed [ProdW-1:0]  bx_q, ay;
		logic signed [DelayW-1:0] next_d;
		logic signed [UpdW-1:0]   upd;
		logic signed [DelayW-1:0] upd_sat;

		// b3, a3 and any higher coefficients have no registers and stay zero
		if (k == 0) begin : g_c1
			assign b_k = coef.b1;
			assign a_k = coef.a1;
		end else if (k == 1) begin : g_c2
			assign b_k = coef.b2;
			assign a_k = coef.a2;
		end else begin : g_cz
			assign b_k = '0;
			assign a_k = '0;
		end

		if (k + 1 < ORDER) begin : g_next
			assign next_d = delay_q[k+1];
		end else begin : g_last
			assign next_d = '0;
		end

		// Feed-forward product, taken in the first step
		always_ff @(posedge clk) begin
			if (cmd.mac1) begin
				bx_q <= b_k * item_q.sample_in;
			end
		end

		// Second step: feedback and delay update with saturation
		always_comb begin
			ay  = a_k * y_q;
			upd = UpdW'(bx_q) - UpdW'(ay) + UpdW'(next_d);
			if ((&upd[UpdW-1:DelayW-1]) || !(|upd[UpdW-1:DelayW-1])) begin
				upd_sat = upd[DelayW-1:0];
			end else begin
				upd_sat = upd[UpdW-1] ? {1'b1, {(DelayW-1){1'b0}}}
				                      : {1'b0, {(DelayW-1){1'b1}}};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				delay_q[k] <= '0;
			end else if (cmd.mac2) begin
				delay_q[k] <= upd_sat;
			end else if (cmd.preload && (int'(item_q.delay_index) == k)) begin
				delay_q[k] <= item_q.delay_value;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_q.sample_out <= y_q;
			out_q.saturated  <= sat_q;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

### sv/iirtf_checker.sv
`default_nettype none

module iirtf_checker
	import iirtf_pkg::*;
(
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_stall,
	input in_item_t          in_data,
	input wire               out_valid,
	input wire               out_stall,
	input out_item_t         out_data,
	input wire               cfg_valid,
	input wire               cfg_ready,
	input wire [CfgIdxW-1:0] cfg_index,
	input wire [CoefW-1:0]   cfg_data
);

	logic filt_acc;
	assign filt_acc = in_valid && !in_stall && (in_data.opcode == OP_FILTER);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// A filter transaction blocks the input for its first step
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		filt_acc |=> in_stall)
		else $error("input taken during a filter step");

	// A fresh result comes from an earlier filter transaction
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(filt_acc, 3))
		else $error("result without a matching filter transaction");

	// A register write carries a known index and value
	a_cfg_known: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !$isunknown({cfg_index, cfg_data}))
		else $error("register write with unknown index or data");

endmodule

bind iir_transposed_direct_form_filter_core iirtf_checker u_checker (.*);

`default_nettype wire
